// ===== rtl/core/triangle_raster_msaa_zbuffer_macros.svh =====
// Assertion macros for the rasterizer block.
// Included by the top level; no other dependencies.
`ifndef TRIANGLE_RASTER_MSAA_ZBUFFER_MACROS_SVH
`define TRIANGLE_RASTER_MSAA_ZBUFFER_MACROS_SVH
`ifndef SYNTH
`define TRZ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TRZ_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRZ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRZ_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/trz_pkg.sv =====
// Shared types, action codes and helpers of the rasterizer block.
// No dependencies.
package trz_pkg;

    localparam int CW = 12;   // pixel coordinate bits (screen up to 4096)

    localparam logic [2:0] ACT_DRAW     = 3'd0;
    localparam logic [2:0] ACT_CLR_COL  = 3'd1;
    localparam logic [2:0] ACT_CLR_DEP  = 3'd2;
    localparam logic [2:0] ACT_CLR_BOTH = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;

    localparam logic [23:0] DEPTH_FAR = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] vertex0_x;
        logic signed [15:0] vertex0_y;
        logic [23:0]        vertex0_z;
        logic signed [15:0] vertex1_x;
        logic signed [15:0] vertex1_y;
        logic [23:0]        vertex1_z;
        logic signed [15:0] vertex2_x;
        logic signed [15:0] vertex2_y;
        logic [23:0]        vertex2_z;
        logic [23:0]        tri_color;
        logic [13:0]        read_index;
    } t_in;

    typedef struct packed {
        logic [23:0] pixel_color;
        logic [23:0] pixel_depth;
        logic [14:0] pixels_written;
    } t_out;

    // classified command as it sits in the queue
    typedef struct packed {
        t_in           req;
        logic [CW-1:0] min_x;
        logic [CW-1:0] max_x;
        logic [CW-1:0] min_y;
        logic [CW-1:0] max_y;
        logic          empty;
    } t_cmd;

    function automatic logic [23:0] scale_color(input logic [23:0] c, input logic [2:0] k);
        logic [10:0] r;
        logic [10:0] g;
        logic [10:0] b;
        r = 11'(c[23:16]) * 11'(k);
        g = 11'(c[15:8]) * 11'(k);
        b = 11'(c[7:0]) * 11'(k);
        return {r[9:2], g[9:2], b[9:2]};
    endfunction

endpackage

// ===== rtl/core/trz_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trz_ram #(
    parameter int DW    = 24,
    parameter int DEPTH = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DW-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DW-1:0]                     o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/trz_front.sv =====
// Front end: accepts transactions, computes the clipped bounding box.
// Depends on trz_pkg.
module trz_front
    import trz_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 128
) (
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_ready,
    input  logic i_init,
    input  logic i_q_ready,
    output logic o_push,
    output t_cmd o_cmd
);
    localparam logic signed [13:0] XMAX = 14'(WIDTH - 1);
    localparam logic signed [13:0] YMAX = 14'(HEIGHT - 1);

    logic signed [15:0] mnx, mxx, mny, mxy;
    logic signed [16:0] cx17, cy17;
    logic signed [13:0] lox, hix, loy, hiy;

    always_comb begin
        mnx = i_in_data.vertex0_x;
        mxx = i_in_data.vertex0_x;
        mny = i_in_data.vertex0_y;
        mxy = i_in_data.vertex0_y;
        if (i_in_data.vertex1_x < mnx) mnx = i_in_data.vertex1_x;
        if (i_in_data.vertex2_x < mnx) mnx = i_in_data.vertex2_x;
        if (i_in_data.vertex1_x > mxx) mxx = i_in_data.vertex1_x;
        if (i_in_data.vertex2_x > mxx) mxx = i_in_data.vertex2_x;
        if (i_in_data.vertex1_y < mny) mny = i_in_data.vertex1_y;
        if (i_in_data.vertex2_y < mny) mny = i_in_data.vertex2_y;
        if (i_in_data.vertex1_y > mxy) mxy = i_in_data.vertex1_y;
        if (i_in_data.vertex2_y > mxy) mxy = i_in_data.vertex2_y;

        // floor of min / 16, ceil of max / 16
        cx17 = {mxx[15], mxx} + 17'sd15;
        cy17 = {mxy[15], mxy} + 17'sd15;
        lox = 14'($signed(mnx[15:4]));
        loy = 14'($signed(mny[15:4]));
        hix = 14'($signed(cx17[16:4]));
        hiy = 14'($signed(cy17[16:4]));
        if (lox < 14'sd0) lox = 14'sd0;
        if (loy < 14'sd0) loy = 14'sd0;
        if (hix > XMAX) hix = XMAX;
        if (hiy > YMAX) hiy = YMAX;

        o_cmd.req   = i_in_data;
        o_cmd.min_x = lox[CW-1:0];
        o_cmd.max_x = hix[CW-1:0];
        o_cmd.min_y = loy[CW-1:0];
        o_cmd.max_y = hiy[CW-1:0];
        o_cmd.empty = (lox > hix) || (loy > hiy);
    end

    assign o_in_ready = i_q_ready && !i_init;
    assign o_push     = i_in_valid && o_in_ready;
endmodule

// ===== rtl/core/trz_queue.sv =====
// Two-entry command queue between front end and back end.
// Depends on trz_pkg.
module trz_queue
    import trz_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_data,
    input  logic i_pop
);
    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       n_wp, n_rp;
    logic [1:0] n_count;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_slot[r_rp];

    always_comb begin
        n_wp    = r_wp ^ i_push;
        n_rp    = r_rp ^ i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_data;
        end
    end
endmodule

// ===== rtl/core/trz_back.sv =====
// Back end: clears, reads, and walks the pixel box of a draw with
// incremental edge functions and a serial depth divider. Owns both stores.
// Depends on trz_pkg and trz_ram.
module trz_back
    import trz_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_ready,
    output logic o_init
);
    localparam int NPIX = WIDTH * HEIGHT;
    localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int EW   = 40;   // edge / area values
    localparam int NW   = 68;   // depth numerator
    localparam int PW   = 58;   // multiplier product
    localparam logic [AW-1:0] LAST   = AW'(NPIX - 1);
    localparam logic [AW-1:0] W_STEP = AW'(WIDTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_RDOUT = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_PIX   = 4'd4;
    localparam logic [3:0] S_DPRE  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // setup sequence: one multiply per step, registered and accumulated in the next step
    localparam logic [4:0] ST_EY   = 5'd0;
    localparam logic [4:0] ST_EX   = 5'd3;
    localparam logic [4:0] ST_S    = 5'd6;
    localparam logic [4:0] ST_NLO  = 5'd8;
    localparam logic [4:0] ST_NHI  = 5'd11;
    localparam logic [4:0] ST_NDX  = 5'd14;
    localparam logic [4:0] ST_NDY  = 5'd17;
    localparam logic [4:0] ST_LAST = 5'd20;
    localparam logic [4:0] ST_END  = 5'd21;

    function automatic logic [1:0] nxt(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // control
    logic [3:0]    r_state, n_state;
    logic          r_init, n_init;
    logic          r_ovalid, n_ovalid;
    logic [4:0]    r_step, n_step;
    logic          r_pv, n_pv;
    // payload
    t_cmd          r_cmd, n_cmd;
    t_out          r_out, n_out;
    logic [1:0]    r_mask, n_mask;
    logic [AW-1:0] r_sweep, n_sweep;
    logic signed [PW-1:0] r_prod, n_prod;
    logic [4:0]    r_pstep, n_pstep;
    logic signed [EW-1:0] r_e [3];
    logic signed [EW-1:0] n_e [3];
    logic signed [EW-1:0] r_ec [3];
    logic signed [EW-1:0] n_ec [3];
    logic signed [EW-1:0] r_s, n_s;
    logic signed [NW-1:0] r_num, n_num, r_numc, n_numc, r_ndx, n_ndx, r_ndy, n_ndy;
    logic [CW-1:0] r_x, n_x, r_y, n_y;
    logic [AW-1:0] r_idx, n_idx, r_idxc, n_idxc;
    logic [2:0]    r_k, n_k;
    logic signed [NW-1:0] r_rem, n_rem;
    logic [59:0]   r_dsh, n_dsh;
    logic [4:0]    r_dc, n_dc;
    logic [23:0]   r_q, n_q, r_zold, n_zold;
    logic [14:0]   r_cnt, n_cnt;
    logic [23:0]   r_rcol, n_rcol, r_rdep, n_rdep;

    // stores
    logic          col_we, dep_we;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   col_wdata, dep_wdata, col_rdata, dep_rdata;

    trz_ram #(.DW(24), .DEPTH(NPIX)) u_color (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(waddr), .i_wdata(col_wdata),
        .i_raddr(raddr), .o_rdata(col_rdata)
    );
    trz_ram #(.DW(24), .DEPTH(NPIX)) u_depth (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(waddr), .i_wdata(dep_wdata),
        .i_raddr(raddr), .o_rdata(dep_rdata)
    );

    // triangle terms
    logic signed [15:0] vx [3];
    logic signed [15:0] vy [3];
    logic [23:0]        vz [3];
    logic signed [16:0] ea [3];   // d(edge)/dx
    logic signed [16:0] eb [3];   // d(edge)/dy
    logic signed [EW-1:0] ecn [3]; // edge value at pixel corner
    logic signed [17:0] px0, py0;

    assign vx[0] = r_cmd.req.vertex0_x;
    assign vx[1] = r_cmd.req.vertex1_x;
    assign vx[2] = r_cmd.req.vertex2_x;
    assign vy[0] = r_cmd.req.vertex0_y;
    assign vy[1] = r_cmd.req.vertex1_y;
    assign vy[2] = r_cmd.req.vertex2_y;
    assign vz[0] = r_cmd.req.vertex0_z;
    assign vz[1] = r_cmd.req.vertex1_z;
    assign vz[2] = r_cmd.req.vertex2_z;
    assign px0 = $signed({2'b00, r_cmd.min_x, 4'd4});
    assign py0 = $signed({2'b00, r_cmd.min_y, 4'd4});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ea[i]  = 17'(vy[nxt(2'(i))]) - 17'(vy[i]);
            eb[i]  = 17'(vx[i]) - 17'(vx[nxt(2'(i))]);
            ecn[i] = r_e[i] - (EW'(ea[i]) <<< 2) - (EW'(eb[i]) <<< 2);
        end
    end

    // shared setup multiplier
    logic signed [EW-1:0] mul_a;
    logic signed [17:0]   mul_b;
    logic [1:0]           gi;
    logic signed [PW-1:0] prod_w;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        gi    = 2'd0;
        if (r_step < ST_EX) begin
            gi    = 2'(r_step - ST_EY);
            mul_a = EW'(py0 - 18'(vy[gi]));
            mul_b = 18'(eb[gi]);
        end else if (r_step < ST_S) begin
            gi    = 2'(r_step - ST_EX);
            mul_a = EW'(px0 - 18'(vx[gi]));
            mul_b = 18'(ea[gi]);
        end else if (r_step == ST_S) begin
            mul_a = EW'(17'(vy[2]) - 17'(vy[0]));
            mul_b = 18'(eb[0]);
        end else if (r_step < ST_NLO) begin
            mul_a = EW'(17'(vx[2]) - 17'(vx[0]));
            mul_b = 18'(ea[0]);
        end else if (r_step < ST_NHI) begin
            gi    = 2'(r_step - ST_NLO);
            mul_a = ecn[nxt(gi)];
            mul_b = $signed({6'd0, vz[gi][11:0]});
        end else if (r_step < ST_NDX) begin
            gi    = 2'(r_step - ST_NHI);
            mul_a = ecn[nxt(gi)];
            mul_b = $signed({6'd0, vz[gi][23:12]});
        end else if (r_step < ST_NDY) begin
            gi    = 2'(r_step - ST_NDX);
            mul_a = $signed({16'd0, vz[gi]});
            mul_b = 18'(ea[nxt(gi)]);
        end else if (r_step < ST_LAST) begin
            gi    = 2'(r_step - ST_NDY);
            mul_a = $signed({16'd0, vz[gi]});
            mul_b = 18'(eb[nxt(gi)]);
        end
    end

    assign prod_w = PW'(mul_a) * PW'(mul_b);

    // four-sample coverage of the current pixel
    logic [3:0] cov;
    logic [2:0] kcnt;
    always_comb begin
        logic signed [EW-1:0] ev;
        logic allp, alln;
        for (int s = 0; s < 4; s++) begin
            allp = 1'b1;
            alln = 1'b1;
            for (int i = 0; i < 3; i++) begin
                ev = r_e[i];
                if (s[1]) ev = ev + (EW'(ea[i]) <<< 3);
                if (s[0]) ev = ev + (EW'(eb[i]) <<< 3);
                allp = allp && (ev > 0);
                alln = alln && (ev < 0);
            end
            cov[s] = allp || alln;
        end
        kcnt = 3'(cov[0]) + 3'(cov[1]) + 3'(cov[2]) + 3'(cov[3]);
    end

    // divisor |S|; S = -r_s
    logic        sneg;
    logic [35:0] dabs;
    logic signed [EW-1:0] s_abs;
    logic [24:0] idx_base;
    logic        rd_ok;
    logic        qbit;

    assign sneg     = (r_s > 0);
    assign s_abs    = sneg ? r_s : -r_s;
    assign dabs     = s_abs[35:0];
    assign idx_base = (25'(HEIGHT - 1) - 25'(r_cmd.min_y)) * 25'(WIDTH) + 25'(r_cmd.min_x);
    assign rd_ok    = (25'(i_cmd.req.read_index) < 25'(NPIX));
    assign qbit     = (r_rem >= $signed({8'd0, r_dsh}));

    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_ovalid = r_ovalid;
        n_step   = r_step;
        n_pv     = r_pv;
        n_cmd    = r_cmd;
        n_out    = r_out;
        n_mask   = r_mask;
        n_sweep  = r_sweep;
        n_prod   = r_prod;
        n_pstep  = r_pstep;
        n_e      = r_e;
        n_ec     = r_ec;
        n_s      = r_s;
        n_num    = r_num;
        n_numc   = r_numc;
        n_ndx    = r_ndx;
        n_ndy    = r_ndy;
        n_x      = r_x;
        n_y      = r_y;
        n_idx    = r_idx;
        n_idxc   = r_idxc;
        n_k      = r_k;
        n_rem    = r_rem;
        n_dsh    = r_dsh;
        n_dc     = r_dc;
        n_q      = r_q;
        n_zold   = r_zold;
        n_cnt    = r_cnt;
        n_rcol   = r_rcol;
        n_rdep   = r_rdep;
        o_cmd_pop = 1'b0;
        col_we    = 1'b0;
        dep_we    = 1'b0;
        waddr     = r_idx;
        raddr     = r_idx;
        col_wdata = scale_color(r_cmd.req.tri_color, r_k);
        dep_wdata = r_q;

        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                raddr = AW'(i_cmd.req.read_index);
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_cnt     = '0;
                    n_rcol    = '0;
                    n_rdep    = '0;
                    n_sweep   = '0;
                    n_mask    = i_cmd.req.action[1:0];
                    n_x       = i_cmd.min_x;
                    n_y       = i_cmd.min_y;
                    n_step    = ST_EY;
                    n_pv      = 1'b0;
                    n_s       = '0;
                    n_num     = '0;
                    n_ndx     = '0;
                    n_ndy     = '0;
                    for (int i = 0; i < 3; i++) n_e[i] = '0;
                    case (i_cmd.req.action)
                        ACT_DRAW:     n_state = i_cmd.empty ? S_DONE : S_SETUP;
                        ACT_CLR_COL:  n_state = S_CLEAR;
                        ACT_CLR_DEP:  n_state = S_CLEAR;
                        ACT_CLR_BOTH: n_state = S_CLEAR;
                        ACT_READ:     n_state = rd_ok ? S_RDOUT : S_DONE;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                waddr     = r_sweep;
                col_we    = r_mask[0];
                dep_we    = r_mask[1];
                col_wdata = '0;
                dep_wdata = DEPTH_FAR;
                if (r_sweep == LAST) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_RDOUT: begin
                n_rcol  = col_rdata;
                n_rdep  = dep_rdata;
                n_state = S_DONE;
            end
            S_SETUP: begin
                n_step  = r_step + 5'd1;
                n_prod  = prod_w;
                n_pstep = r_step;
                n_pv    = (r_step < ST_LAST);
                if (r_step == ST_EY) begin
                    n_idxc = AW'(idx_base);
                    n_idx  = AW'(idx_base);
                end
                if (r_pv) begin
                    if (r_pstep < ST_EX) begin
                        n_e[2'(r_pstep - ST_EY)] = r_e[2'(r_pstep - ST_EY)] + EW'(r_prod);
                    end else if (r_pstep < ST_S) begin
                        n_e[2'(r_pstep - ST_EX)] = r_e[2'(r_pstep - ST_EX)] + EW'(r_prod);
                    end else if (r_pstep < ST_NLO) begin
                        n_s = r_s + EW'(r_prod);
                    end else if (r_pstep < ST_NHI) begin
                        n_num = r_num - NW'(r_prod);
                    end else if (r_pstep < ST_NDX) begin
                        n_num = r_num - (NW'(r_prod) <<< 12);
                    end else if (r_pstep < ST_NDY) begin
                        n_ndx = r_ndx - NW'(r_prod);
                    end else begin
                        n_ndy = r_ndy - NW'(r_prod);
                    end
                end
                if (r_step == ST_END) begin
                    n_ec    = r_e;
                    n_numc  = r_num;
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                if (kcnt == 3'd0 || r_s == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_k     = kcnt;
                    n_rem   = sneg ? -r_num : r_num;
                    n_state = S_DPRE;
                end
            end
            S_DPRE: begin
                n_zold = dep_rdata;
                if (r_rem < 0) begin
                    n_q     = '0;
                    n_state = S_CMP;
                end else if (r_rem >= $signed({8'd0, dabs, 24'd0})) begin
                    n_q     = DEPTH_FAR;
                    n_state = S_CMP;
                end else begin
                    n_dsh   = {1'b0, dabs, 23'd0};
                    n_q     = '0;
                    n_dc    = 5'd23;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (qbit) n_rem = r_rem - $signed({8'd0, r_dsh});
                n_q   = {r_q[22:0], qbit};
                n_dsh = r_dsh >> 1;
                if (r_dc == 5'd0) begin
                    n_state = S_CMP;
                end else begin
                    n_dc = r_dc - 5'd1;
                end
            end
            S_CMP: begin
                if (r_q < r_zold) begin
                    col_we = 1'b1;
                    dep_we = 1'b1;
                    if (r_cnt != 15'h7FFF) n_cnt = r_cnt + 15'd1;
                end
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_state = S_PIX;
                if (r_y == r_cmd.max_y) begin
                    if (r_x == r_cmd.max_x) begin
                        n_state = S_DONE;
                    end else begin
                        n_x = r_x + 1'b1;
                        n_y = r_cmd.min_y;
                        for (int i = 0; i < 3; i++) begin
                            n_ec[i] = r_ec[i] + (EW'(ea[i]) <<< 4);
                            n_e[i]  = r_ec[i] + (EW'(ea[i]) <<< 4);
                        end
                        n_numc = r_numc + (r_ndx <<< 4);
                        n_num  = r_numc + (r_ndx <<< 4);
                        n_idxc = r_idxc + 1'b1;
                        n_idx  = r_idxc + 1'b1;
                    end
                end else begin
                    n_y = r_y + 1'b1;
                    for (int i = 0; i < 3; i++) n_e[i] = r_e[i] + (EW'(eb[i]) <<< 4);
                    n_num = r_num + (r_ndy <<< 4);
                    n_idx = r_idx - W_STEP;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out.pixel_color    = r_rcol;
                    n_out.pixel_depth    = r_rdep;
                    n_out.pixels_written = r_cnt;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // no new command while the power-up clearing pass runs
        if (r_init && r_state == S_IDLE) o_cmd_pop = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_init   <= 1'b1;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_pv     <= 1'b0;
            r_mask   <= 2'b11;
            r_sweep  <= '0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            r_step   <= n_step;
            r_pv     <= n_pv;
            r_mask   <= n_mask;
            r_sweep  <= n_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_out   <= n_out;
        r_prod  <= n_prod;
        r_pstep <= n_pstep;
        r_e     <= n_e;
        r_ec    <= n_ec;
        r_s     <= n_s;
        r_num   <= n_num;
        r_numc  <= n_numc;
        r_ndx   <= n_ndx;
        r_ndy   <= n_ndy;
        r_x     <= n_x;
        r_y     <= n_y;
        r_idx   <= n_idx;
        r_idxc  <= n_idxc;
        r_k     <= n_k;
        r_rem   <= n_rem;
        r_dsh   <= n_dsh;
        r_dc    <= n_dc;
        r_q     <= n_q;
        r_zold  <= n_zold;
        r_cnt   <= n_cnt;
        r_rcol  <= n_rcol;
        r_rdep  <= n_rdep;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_init      = r_init;
endmodule

// ===== rtl/core/triangle_raster_msaa_zbuffer.sv =====
// Top level of the 4x multisampled triangle rasterizer with depth buffer.
// Depends on trz_pkg, trz_front, trz_queue, trz_back, trz_ram and the macro header.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one action per transaction:
//   draw, clear color, clear depth, clear both, or read one pixel.
//   Output channel o_out_valid / i_out_ready returns exactly one result per
//   action: the stored pixel for an in-range read, the passed-pixel count for a draw,
//   zeros otherwise.
//   A clear sweeps every pixel of the selected stores; a draw runs a setup
//   sequence and then visits each pixel of the clipped box, skipping the
//   depth test when no sample is covered, using a clamped depth without
//   division when the depth saturates, and otherwise running the
//   one-bit-per-cycle depth divider. Actions run one at a time in the back end.
//   A two-entry queue lets new transactions be taken while the back end works
//   and while a result waits in the output register.
//   Reset starts a clearing pass over every address of both stores;
//   o_in_ready stays low until it ends.
//   When the receiver stalls, the finished result is held in the output
//   register and the back end waits before posting the next one.
`include "triangle_raster_msaa_zbuffer_macros.svh"
module triangle_raster_msaa_zbuffer
    import trz_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    logic w_init, w_q_ready, w_push, w_pop, w_q_valid;
    t_cmd w_cmd, w_q_cmd;

    trz_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_ready(o_in_ready),
        .i_init(w_init), .i_q_ready(w_q_ready), .o_push(w_push), .o_cmd(w_cmd)
    );

    trz_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_push_data(w_cmd), .o_push_ready(w_q_ready),
        .o_pop_valid(w_q_valid), .o_pop_data(w_q_cmd), .i_pop(w_pop)
    );

    trz_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_q_valid), .i_cmd(w_q_cmd), .o_cmd_pop(w_pop),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_ready(i_out_ready),
        .o_init(w_init)
    );

    `TRZ_ASSERT_NR(a_init_after_rst, i_clk, !i_rst_n |=> w_init, "clearing pass not started")
    `TRZ_ASSERT_NR(a_no_out_after_rst, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")
    `TRZ_ASSERT(a_no_out_in_init, i_clk, i_rst_n, w_init |-> !o_out_valid, "result during clear pass")
    `TRZ_ASSERT(a_draw_only_count, i_clk, i_rst_n, o_out_valid && (o_out_data.pixels_written != 15'd0) |-> (o_out_data.pixel_color == 24'd0 && o_out_data.pixel_depth == 24'd0), "draw result carries pixel data")
endmodule
